// ===== rtl/core/cfq_pkg.sv =====
// cuckoo filter package: constants, item types and hash helper functions
// no dependencies
package cfq_pkg;

    localparam int BUCKET_DEPTH = 1024;
    localparam int IDX_W        = 10;
    localparam int KICK_LIMIT   = 500;
    localparam int KICK_W       = 9;
    localparam int ADDR_W       = 5;

    localparam logic [63:0] FP_SALT  = 64'hc6a4a7935bd1e995;
    localparam logic [63:0] CITY_MUL = 64'h9ddfea08eb382d69;
    localparam logic [63:0] FMIX_M1  = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_M2  = 64'hc4ceb9fe1a85ec53;

    localparam logic [1:0] MODE_QUERY  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [ADDR_W-1:0] REG_WIDE = 5'h00;
    localparam logic [ADDR_W-1:0] REG_SEED = 5'h08;
    localparam logic [ADDR_W-1:0] REG_BCNT = 5'h10;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] key_hash;
    } req_t;

    typedef struct packed {
        logic              success;
        logic [KICK_W-1:0] kicks_used;
    } rsp_t;

    // 64x64 low product from three 32x32 partial products
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } part_t;

    function automatic part_t mul_parts(input logic [63:0] a, input logic [63:0] b);
        part_t p;
        p.ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        p.lh = a[31:0] * b[63:32];
        p.hl = a[63:32] * b[31:0];
        return p;
    endfunction

    function automatic logic [63:0] mul_sum(input part_t p);
        return p.ll + {p.lh + p.hl, 32'd0};
    endfunction

endpackage

// ===== rtl/core/cfq_if.sv =====
// valid/ready channel carrying a payload struct
// depends on nothing
interface cfq_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/cfq_mixer.sv =====
// shared multi-cycle mixing unit: fmix64 and city 128-to-64 mix
// depends on cfq_pkg; one 64x64 multiply done as partial products per step
module cfq_mixer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        city,
    input  logic [63:0] lo,
    input  logic [63:0] hi,
    output logic        done,
    output logic [63:0] result
);
    // program: mul steps with pre/post xor-shifts
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PART = 4'b0010,
        S_SUM  = 4'b0100,
        S_DONE = 4'b1000
    } mstate_t;

    mstate_t state_reg, state_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] hi_reg, hi_next;
    logic [1:0]  step_reg, step_next;
    logic        city_reg, city_next;
    cfq_pkg::part_t part_reg, part_next;
    logic [63:0] mul_const, prod;

    always_comb
    begin
        unique case ({city_reg, step_reg})
            3'b000:  mul_const = cfq_pkg::FMIX_M1;
            3'b001:  mul_const = cfq_pkg::FMIX_M2;
            default: mul_const = cfq_pkg::CITY_MUL;
        endcase
    end

    assign prod = cfq_pkg::mul_sum(part_reg);

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        hi_next    = hi_reg;
        step_next  = step_reg;
        city_next  = city_reg;
        part_next  = part_reg;
        unique case (state_reg)
            S_IDLE, S_DONE:
            begin
                state_next = S_IDLE;
                if (start)
                begin
                    city_next = city;
                    hi_next   = hi;
                    step_next = 2'd0;
                    x_next    = city ? (lo ^ hi) : (lo ^ (lo >> 33));
                    state_next = S_PART;
                end
            end
            S_PART:
            begin
                part_next  = cfq_pkg::mul_parts(x_reg, mul_const);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_PART;
                step_next  = step_reg + 2'd1;
                if (!city_reg)
                begin
                    x_next = prod ^ (prod >> 33);
                    if (step_reg == 2'd1)
                        state_next = S_DONE;
                end
                else
                begin
                    unique case (step_reg)
                        2'd0:    x_next = hi_reg ^ (prod ^ (prod >> 47));
                        2'd1:    x_next = prod ^ (prod >> 47);
                        default:
                        begin
                            x_next     = prod;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        hi_reg   <= hi_next;
        step_reg <= step_next;
        city_reg <= city_next;
        part_reg <= part_next;
    end

    assign done   = (state_reg == S_DONE);
    assign result = x_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("mixer done held");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_SUM) else $error("mixer done out of order");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        !city_reg && state_reg == S_SUM |-> step_reg <= 2'd1)
        else $error("fmix step overrun");
endmodule

// ===== rtl/core/cuckoo_filter_insert_query.sv =====
// cuckoo filter top level: apb registers, sequencer, bucket memory
// depends on cfq_pkg, cfq_if, cfq_mixer
//
//  channel | dir | payload                   | handshake
//  in_ch   | in  | mode[1:0], key_hash[63:0] | valid/ready
//  out_ch  | out | success, kicks_used[8:0]  | valid/ready
//  apb     | in  | paddr[4:0], pwdata[63:0]  | psel/penable, pready=1
//
// one item at a time; a query or an insert that finds a free slot gives its
// result after the city mix, two fmix passes, two bucket reads and the output
// state; each eviction adds a slot swap, an fmix for the alternate bucket and
// a free-slot check; an unused mode or a zero bucket count goes straight to
// the output state
// a clear sweeps all 1024 memory rows, one per cycle; after reset the same
// sweep runs before the first item is taken
// a result still waiting on out_ch holds off the next item
module cuckoo_filter_insert_query (
    input  logic                        clk,
    input  logic                        rst_n,
    cfq_if.sink                         in_ch,
    cfq_if.source                       out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfq_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);
    typedef enum logic [12:0] {
        S_CLR   = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_FP    = 13'b0000000000100,
        S_B1    = 13'b0000000001000,
        S_ALT   = 13'b0000000010000,
        S_RD1   = 13'b0000000100000,
        S_RD2   = 13'b0000001000000,
        S_CHK   = 13'b0000010000000,
        S_KRD   = 13'b0000100000000,
        S_KWR   = 13'b0001000000000,
        S_KALT  = 13'b0010000000000,
        S_KFREE = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    localparam int IW = cfq_pkg::IDX_W;

    state_t state_reg, state_next;
    logic        wide_reg;
    logic [63:0] seed_reg;
    logic [10:0] bcnt_reg;
    logic [1:0]  mode_reg, mode_next;
    logic [63:0] hash_reg, hash_next;
    logic [15:0] fp_reg, fp_next;
    logic [IW-1:0] b1_reg, b1_next, b2_reg, b2_next, bk_reg, bk_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [cfq_pkg::KICK_W-1:0] kick_reg, kick_next;
    logic        ok_reg, ok_next;
    logic        ovalid_reg, ovalid_next;
    logic        osucc_reg;
    logic [cfq_pkg::KICK_W-1:0] okick_reg;
    logic        fin;

    // memory
    logic [63:0] mem [cfq_pkg::BUCKET_DEPTH];
    logic [63:0] rdata;
    logic [IW-1:0] raddr, waddr;
    logic        we;
    logic [63:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

    // mixer
    logic        mx_start, mx_city, mx_done;
    logic [63:0] mx_lo, mx_hi, mx_res;

    cfq_mixer u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mx_start),
        .city   (mx_city),
        .lo     (mx_lo),
        .hi     (mx_hi),
        .done   (mx_done),
        .result (mx_res)
    );

    // apb
    assign pready = 1'b1;
    always_comb
    begin
        unique case (paddr)
            cfq_pkg::REG_WIDE: prdata = {63'd0, wide_reg};
            cfq_pkg::REG_SEED: prdata = seed_reg;
            cfq_pkg::REG_BCNT: prdata = {53'd0, bcnt_reg};
            default:           prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg <= 1'b0;
            seed_reg <= 64'd0;
            bcnt_reg <= 11'd0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                cfq_pkg::REG_WIDE: wide_reg <= pwdata[0];
                cfq_pkg::REG_SEED: seed_reg <= pwdata;
                cfq_pkg::REG_BCNT: bcnt_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    logic [15:0] fmask;
    logic [IW-1:0] imask;
    assign fmask = wide_reg ? 16'hFFFF : 16'h00FF;
    assign imask = IW'(bcnt_reg - 11'd1);

    // slot helpers on the word just read
    logic [15:0] lane [4];
    logic [3:0]  hit, empty;
    logic [1:0]  free_s, kslot;
    always_comb
    begin
        for (int s = 0; s < 4; s++)
        begin
            lane[s]  = rdata[16*s +: 16] & fmask;
            hit[s]   = (lane[s] == fp_reg);
            empty[s] = (lane[s] == 16'd0);
        end
        priority casez (empty)
            4'b???1: free_s = 2'd0;
            4'b??10: free_s = 2'd1;
            4'b?100: free_s = 2'd2;
            default: free_s = 2'd3;
        endcase
    end
    assign kslot = hash_reg[1:0] + kick_reg[1:0];

    function automatic logic [63:0] put(input logic [63:0] w, input logic [1:0] s,
                                        input logic [15:0] f);
        logic [63:0] r;
        r = w;
        r[16*s +: 16] = f;
        return r;
    endfunction

    assign in_ch.ready = (state_reg == S_IDLE) && !(ovalid_reg && !out_ch.ready);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data.success    = osucc_reg;
    assign out_ch.data.kicks_used = okick_reg;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        hash_next  = hash_reg;
        fp_next    = fp_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        bk_next    = bk_reg;
        clr_next   = clr_reg;
        kick_next  = kick_reg;
        ok_next    = ok_reg;
        mx_start   = 1'b0;
        mx_city    = 1'b0;
        mx_lo      = hash_reg;
        mx_hi      = seed_reg ^ cfq_pkg::FP_SALT;
        raddr      = b1_reg;
        we         = 1'b0;
        waddr      = bk_reg;
        wdata      = 64'd0;
        fin        = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    ok_next = 1'b1;
                    fin     = (mode_reg == cfq_pkg::MODE_CLEAR);
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    mode_next = in_ch.data.mode;
                    hash_next = in_ch.data.key_hash;
                    kick_next = '0;
                    ok_next   = 1'b0;
                    clr_next  = '0;
                    if (in_ch.data.mode == cfq_pkg::MODE_CLEAR)
                        state_next = S_CLR;
                    else if (in_ch.data.mode == cfq_pkg::MODE_UNUSED || bcnt_reg == 11'd0)
                        state_next = S_OUT;
                    else
                    begin
                        mx_start = 1'b1;
                        mx_city  = 1'b1;
                        mx_lo    = in_ch.data.key_hash;
                        state_next = S_FP;
                    end
                end
            end
            S_FP:
            begin
                if (mx_done)
                begin
                    fp_next = ((mx_res[15:0] & fmask) == 16'd0) ? 16'd1
                                                                 : (mx_res[15:0] & fmask);
                    mx_start = 1'b1;
                    mx_lo    = hash_reg ^ seed_reg;
                    state_next = S_B1;
                end
            end
            S_B1:
            begin
                if (mx_done)
                begin
                    b1_next  = mx_res[IW-1:0] & imask;
                    mx_start = 1'b1;
                    mx_lo    = {48'd0, fp_reg} ^ seed_reg;
                    state_next = S_ALT;
                end
            end
            S_ALT:
            begin
                raddr = b1_reg;
                if (mx_done)
                begin
                    b2_next = (b1_reg ^ mx_res[IW-1:0]) & imask;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                raddr   = b2_reg;
                if (mode_reg == cfq_pkg::MODE_QUERY)
                    ok_next = |hit;
                else if (|empty)
                begin
                    we      = 1'b1;
                    waddr   = b1_reg;
                    wdata   = put(rdata, free_s, fp_reg);
                    ok_next = 1'b1;
                end
                state_next = S_RD2;
            end
            S_RD2:
            begin
                if (mode_reg == cfq_pkg::MODE_QUERY)
                begin
                    ok_next = ok_reg | (|hit);
                    state_next = S_OUT;
                end
                else if (ok_reg)
                    state_next = S_OUT;
                else if (|empty)
                begin
                    we      = 1'b1;
                    waddr   = b2_reg;
                    wdata   = put(rdata, free_s, fp_reg);
                    ok_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    bk_next = hash_reg[1] ? b2_reg : b1_reg;
                    raddr   = hash_reg[1] ? b2_reg : b1_reg;
                    state_next = S_KWR;
                end
            end
            S_KRD:
            begin
                raddr = bk_reg;
                state_next = S_KWR;
            end
            S_KWR:
            begin
                we    = 1'b1;
                waddr = bk_reg;
                wdata = put(rdata, kslot, fp_reg & fmask);
                if (lane[kslot] == 16'd0)
                begin
                    ok_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    kick_next = kick_reg + 1'b1;
                    fp_next   = lane[kslot];
                    mx_start  = 1'b1;
                    mx_lo     = {48'd0, lane[kslot]} ^ seed_reg;
                    state_next = S_KALT;
                end
            end
            S_KALT:
            begin
                if (mx_done)
                begin
                    bk_next = (bk_reg ^ mx_res[IW-1:0]) & imask;
                    raddr   = (bk_reg ^ mx_res[IW-1:0]) & imask;
                    state_next = S_KFREE;
                end
            end
            S_KFREE:
            begin
                if (|empty)
                begin
                    we      = 1'b1;
                    waddr   = bk_reg;
                    wdata   = put(rdata, free_s, fp_reg);
                    ok_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (kick_reg == cfq_pkg::KICK_W'(cfq_pkg::KICK_LIMIT))
                    state_next = S_OUT;
                else
                begin
                    raddr = bk_reg;
                    state_next = S_KWR;
                end
            end
            S_OUT:
            begin
                fin = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign ovalid_next = fin ? 1'b1 : (ovalid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            mode_reg   <= cfq_pkg::MODE_QUERY;
            kick_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            mode_reg   <= mode_next;
            kick_reg   <= kick_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        fp_reg   <= fp_next;
        b1_reg   <= b1_next;
        b2_reg   <= b2_next;
        bk_reg   <= bk_next;
        ok_reg   <= ok_next;
        if (fin)
        begin
            osucc_reg <= ok_next;
            okick_reg <= (mode_reg == cfq_pkg::MODE_INSERT) ? kick_next : '0;
        end
    end

    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |-> state_reg == S_IDLE)
        else $error("item taken while busy");
    a_kick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kick_reg <= cfq_pkg::KICK_W'(cfq_pkg::KICK_LIMIT) || state_reg == S_IDLE)
        else $error("kick limit overrun");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ch.ready |=> ovalid_reg)
        else $error("result lost");
    a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !in_ch.ready) else $error("accept during clear");
endmodule
